### hw/rtl/bayer_threshold_generator_defines.svh
// Assertion macros for the checker file of the threshold generator.
`ifndef BAYER_THRESHOLD_GENERATOR_DEFINES_SVH
`define BAYER_THRESHOLD_GENERATOR_DEFINES_SVH

// Overlapping implication, sampled on clk and idle while arst_n is low.
`define BTG_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Non-overlapping implication, checked in the cycle after the antecedent.
`define BTG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/btg_pkg.sv
// Widths, register indexes and the reciprocal table of the threshold generator.
package btg_pkg;

	localparam int COORD_W     = 8;
	localparam int DIM_W       = 9;
	localparam int OUT_W       = 16;
	localparam int RP1_W       = 17;
	localparam int RECIP_W     = 33;
	localparam int RECIP_SHIFT = 17;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_HEIGHT = 2'd1;

	// floor(2^33 / (4^l + 1)) for each order log2 l.
	function automatic logic [RECIP_W-1:0] recip_f(input logic [3:0] l);
		logic [RECIP_W-1:0] m;
		unique case (l)
			4'd0:    m = 33'd4294967296;
			4'd1:    m = 33'd1717986918;
			4'd2:    m = 33'd505290270;
			4'd3:    m = 33'd132152839;
			4'd4:    m = 33'd33423870;
			4'd5:    m = 33'd8380423;
			4'd6:    m = 33'd2096640;
			4'd7:    m = 33'd524256;
			4'd8:    m = 33'd131070;
			default: m = 33'd131070;
		endcase
		return m;
	endfunction

endpackage

### hw/rtl/btg_rank.sv
// Bayer rank of one position: interleaved, bit-reversed digits cut to the order.
module btg_rank import btg_pkg::*; #(
	parameter int MAX_ORDER_LOG2 = 8,
	parameter int LG_W = $clog2(MAX_ORDER_LOG2 + 1)
) (
	input  logic [COORD_W-1:0] column,
	input  logic [COORD_W-1:0] row,
	input  logic [LG_W-1:0]    order_log2,
	output logic [OUT_W-1:0]   rank
);

	localparam int REV_W = 2 * MAX_ORDER_LOG2;
	localparam int SH_W  = $clog2(REV_W + 1);

	logic [REV_W-1:0] rev;
	logic [REV_W-1:0] shifted;
	logic [SH_W-1:0]  shamt;

	// Each bit level gives a base-4 digit: 3 for column only, 2 for row only,
	// 1 for both. The lowest level carries the highest weight.
	always_comb begin
		for (int b = 0; b < MAX_ORDER_LOG2; b++) begin
			rev[2*(MAX_ORDER_LOG2-1-b) +: 2] = {column[b] ^ row[b], column[b]};
		end
	end

	// Shifting right drops the digits of levels at or above the order.
	assign shamt   = SH_W'(REV_W) - (SH_W'(order_log2) << 1);
	assign shifted = rev >> shamt;
	assign rank    = OUT_W'(shifted);

endmodule

### hw/rtl/bayer_threshold_generator.sv
// Ordered-dither threshold generator: rank and threshold of each position. The pipeline
// has four registered stages (input capture, rank and reciprocal lookup, one 17 by 33
// bit reciprocal multiply, remainder correction into the output register) and takes one
// item per cycle while the output is not stalled; a stalled output holds the last stage,
// and input ready drops only once all four stages are full. The matrix order is worked
// out when kernel_width or kernel_height is written and is carried with each item, so
// new sizes apply from the next item accepted.
module bayer_threshold_generator import btg_pkg::*; #(
	parameter int MAX_ORDER_LOG2 = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [COORD_W-1:0]     column,
	input  logic [COORD_W-1:0]     row,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_W-1:0]       rank,
	output logic [OUT_W-1:0]       threshold_fraction,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]       cfg_data
);

	localparam int LG_W = $clog2(MAX_ORDER_LOG2 + 1);
	localparam logic [LG_W-1:0] LG_RESET = (MAX_ORDER_LOG2 < 3) ? LG_W'(MAX_ORDER_LOG2)
	                                                            : LG_W'(3);

	logic [DIM_W-1:0] width_q, height_q, width_next, height_next, need;
	logic [LG_W-1:0]  lg_q, lg_next;
	logic             cfg_write;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_comb begin
		width_next  = width_q;
		height_next = height_q;
		if (cfg_write && cfg_index == REG_KERNEL_WIDTH) begin
			width_next = cfg_data;
		end
		if (cfg_write && cfg_index == REG_KERNEL_HEIGHT) begin
			height_next = cfg_data;
		end
		need = (width_next > height_next) ? width_next : height_next;
		// The order log2 counts the powers of two below the larger dimension, up to MAX_ORDER_LOG2.
		lg_next = '0;
		for (int i = 0; i < MAX_ORDER_LOG2; i++) begin
			if ((10'd1 << i) < {1'b0, need}) begin
				lg_next = lg_next + LG_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(8);
			height_q <= DIM_W'(8);
			lg_q     <= LG_RESET;
		end else if (cfg_write) begin
			width_q  <= width_next;
			height_q <= height_next;
			lg_q     <= lg_next;
		end
	end

	// Stage control: a stage moves when the one after it is empty or moving.
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	assign adv_s4   = !v_s4 || out_ready;
	assign adv_s3   = !v_s3 || adv_s4;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: capture the position with the order in force.
	logic [COORD_W-1:0] col_s1, row_s1;
	logic [LG_W-1:0]    lg_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			col_s1 <= column;
			row_s1 <= row;
			lg_s1  <= lg_q;
		end
	end

	// Stage 2: rank, rank plus one and the reciprocal of n*n+1.
	logic [OUT_W-1:0]   rank_c;
	logic [OUT_W-1:0]   rank_s2;
	logic [RP1_W-1:0]   rp1_s2;
	logic [RECIP_W-1:0] recip_s2;
	logic [LG_W-1:0]    lg_s2;

	btg_rank #(
		.MAX_ORDER_LOG2(MAX_ORDER_LOG2),
		.LG_W(LG_W)
	) u_rank (
		.column(col_s1),
		.row(row_s1),
		.order_log2(lg_s1),
		.rank(rank_c)
	);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			rank_s2  <= rank_c;
			rp1_s2   <= RP1_W'(rank_c) + RP1_W'(1);
			recip_s2 <= recip_f(4'(lg_s1));
			lg_s2    <= lg_s1;
		end
	end

	// Stage 3: quotient estimate, never above the true quotient and at most one below.
	localparam int PROD_W = RP1_W + RECIP_W;
	logic [PROD_W-1:0] prod;
	logic [OUT_W-1:0]  rank_s3, q0_s3;
	logic [RP1_W-1:0]  rp1_s3;
	logic [LG_W-1:0]   lg_s3;

	assign prod = PROD_W'(rp1_s2) * PROD_W'(recip_s2);

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			rank_s3 <= rank_s2;
			q0_s3   <= prod[RECIP_SHIFT +: OUT_W];
			rp1_s3  <= rp1_s2;
			lg_s3   <= lg_s2;
		end
	end

	// Stage 4: the remainder tells whether the estimate needs one more.
	localparam int REM_W = 34;
	logic [REM_W-1:0] numer, qd, divisor, remainder;
	logic [OUT_W-1:0] rank_s4, thr_s4, thr_c;

	always_comb begin
		numer     = REM_W'({rp1_s3, 16'b0});
		qd        = (REM_W'(q0_s3) << {lg_s3, 1'b0}) + REM_W'(q0_s3);
		divisor   = (REM_W'(1) << {lg_s3, 1'b0}) + REM_W'(1);
		remainder = numer - qd;
		thr_c     = (remainder >= divisor) ? q0_s3 + OUT_W'(1) : q0_s3;
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			rank_s4 <= rank_s3;
			thr_s4  <= thr_c;
		end
	end

	assign out_valid          = v_s4;
	assign rank               = rank_s4;
	assign threshold_fraction = thr_s4;

endmodule

### hw/rtl/btg_checker.sv
// Port-level checks of the threshold generator and their binding to it.
`include "bayer_threshold_generator_defines.svh"

module btg_checker import btg_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic [COORD_W-1:0]     column,
	input logic [COORD_W-1:0]     row,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [OUT_W-1:0]       rank,
	input logic [OUT_W-1:0]       threshold_fraction
);

	// A result that is not taken stays put.
	`BTG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(rank) && $stable(threshold_fraction))

	// The pipeline can only refuse an item when the output is held up.
	`BTG_ASSERT_IMPL(a_full_only_on_stall, !in_ready, out_valid && !out_ready)

	// The origin always has rank zero, and with a free output it comes out of the last stage with that rank.
	`BTG_ASSERT_NEXT(a_origin_rank, in_valid && in_ready && column == '0 && row == '0 ##1 out_ready ##1 out_ready ##1 out_ready, out_valid && rank == '0)

endmodule

bind bayer_threshold_generator btg_checker u_btg_checker (.*);

### tb/sv/tb_bayer_threshold_generator.sv
// Self-checking testbench for the ordered-dither threshold generator.
`timescale 1ns / 100ps

module tb_bayer_threshold_generator;
	import btg_pkg::*;

	localparam int ORDER_LOG2_MAX   = 8;
	localparam int RESULT_LATENCY   = 4;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int ITEMS_PER_SIZE   = 100;
	localparam int SIZES_PER_PHASE  = 5;

	// Indexes beyond the two registers; writes to them must leave the sizes alone.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 2'd3;

	typedef struct packed {
		logic [OUT_W-1:0] rank;
		logic [OUT_W-1:0] frac;
	} threshold_item_t;

	logic                   clk                = 1'b0;
	logic                   arst_n             = 1'b0;
	logic                   in_valid           = 1'b0;
	logic                   in_ready;
	logic [COORD_W-1:0]     column             = '0;
	logic [COORD_W-1:0]     row                = '0;
	logic                   out_valid;
	logic                   out_ready          = 1'b0;
	logic [OUT_W-1:0]       rank;
	logic [OUT_W-1:0]       threshold_fraction;
	logic                   cfg_valid          = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index          = '0;
	logic [DIM_W-1:0]       cfg_data           = '0;

	// Sizes as the block should hold them.
	logic [DIM_W-1:0] size_width  = 9'd8;
	logic [DIM_W-1:0] size_height = 9'd8;

	threshold_item_t pending_thresholds[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_token    = 0;
	int unsigned hold_seen     = 0;
	int unsigned hold_left     = 0;
	int unsigned fail_count    = 0;

	bayer_threshold_generator #(
		.MAX_ORDER_LOG2(ORDER_LOG2_MAX)
	) i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.column            (column),
		.row               (row),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.rank              (rank),
		.threshold_fraction(threshold_fraction),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned matrix_order_log2();
		int unsigned need;
		int unsigned lg;
		need = (size_width > size_height) ? size_width : size_height;
		lg = 0;
		while (lg < ORDER_LOG2_MAX && (1 << lg) < need)
			lg++;
		return lg;
	endfunction

	function automatic threshold_item_t bayer_predict(input logic [COORD_W-1:0] c,
			input logic [COORD_W-1:0] r);
		threshold_item_t res;
		int unsigned     lg;
		int unsigned     acc;
		int unsigned     w;
		logic [63:0]     cells;
		logic [63:0]     num;
		lg = matrix_order_log2();
		acc = 0;
		// The lowest coordinate bit carries the heaviest weight.
		for (int unsigned b = 0; b < lg; b++) begin
			w = 1 << (2 * (lg - 1 - b));
			if (c[b] && r[b])
				acc += w;
			else if (c[b])
				acc += 3 * w;
			else if (r[b])
				acc += 2 * w;
		end
		cells = (64'd1 << (2 * lg)) + 64'd1;
		num = (64'(acc) + 64'd1) << 16;
		res.rank = OUT_W'(acc);
		res.frac = OUT_W'(num / cells);
		return res;
	endfunction

	function automatic void note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch %0d: %s", fail_count, what);
	endfunction

	always @(posedge clk) begin : result_check
		threshold_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_thresholds.size() == 0) begin
				note_failure($sformatf("unexpected item rank=%0d threshold=%0d",
					rank, threshold_fraction));
			end else begin
				want = pending_thresholds.pop_front();
				if (rank !== want.rank)
					note_failure($sformatf("rank expected %0d actual %0d",
						want.rank, rank));
				if (threshold_fraction !== want.frac)
					note_failure($sformatf("threshold expected %0d actual %0d",
						want.frac, threshold_fraction));
			end
		end
	end

	// Output side: random back-pressure, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= LONG_HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic send_item(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		column   <= c;
		row      <= r;
		do @(posedge clk); while (!in_ready);
		pending_thresholds.push_back(bayer_predict(c, r));
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		stop_sending();
		while (pending_thresholds.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [DIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_KERNEL_WIDTH)
			size_width = data;
		else if (idx == REG_KERNEL_HEIGHT)
			size_height = data;
		@(posedge clk);
	endtask

	task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		wait_idle();
		write_register(REG_KERNEL_WIDTH, w);
		write_register(REG_KERNEL_HEIGHT, h);
	endtask

	function automatic logic [DIM_W-1:0] pick_dimension();
		case ($urandom_range(0, 9))
			0: return DIM_W'(0);
			1: return DIM_W'(1);
			2: return DIM_W'(256);
			3: return DIM_W'(511);
			4: return DIM_W'(257);
			5: return DIM_W'($urandom_range(2, 16));
			default: return DIM_W'($urandom_range(0, 511));
		endcase
	endfunction

	task automatic test_reset_size();
		send_item(8'd0, 8'd0);
		send_item(8'd7, 8'd7);
		send_item(8'd3, 8'd5);
		send_item(8'd8, 8'd8);
		send_item(8'd255, 8'd255);
		send_item(8'd255, 8'd0);
		send_item(8'd0, 8'd255);
	endtask

	// A size of zero behaves as one, and one by one gives a single cell.
	task automatic test_degenerate_size();
		set_size(9'd0, 9'd0);
		send_item(8'd0, 8'd0);
		send_item(8'd255, 8'd255);
		set_size(9'd1, 9'd0);
		send_item(8'd170, 8'd85);
		set_size(9'd0, 9'd1);
		send_item(8'd85, 8'd170);
	endtask

	task automatic test_oversized_size();
		set_size(9'd511, 9'd1);
		send_item(8'd255, 8'd255);
		send_item(8'd0, 8'd0);
		send_item(8'd170, 8'd85);
		set_size(9'd256, 9'd256);
		send_item(8'd85, 8'd170);
		send_item(8'd255, 8'd254);
		set_size(9'd3, 9'd257);
		send_item(8'd128, 8'd1);
	endtask

	task automatic test_spare_index();
		set_size(9'd4, 9'd2);
		write_register(REG_SPARE_LOW, 9'h1FF);
		write_register(REG_SPARE_HIGH, 9'd1);
		send_item(8'd3, 8'd3);
		send_item(8'd255, 8'd129);
		send_item(8'd1, 8'd2);
	endtask

	task automatic test_random_stream(input int unsigned sender_pct,
			input int unsigned receiver_pct);
		int unsigned        mask;
		logic [COORD_W-1:0] c;
		logic [COORD_W-1:0] r;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		for (int s = 0; s < SIZES_PER_PHASE; s++) begin
			set_size(pick_dimension(), pick_dimension());
			mask = (1 << matrix_order_log2()) - 1;
			for (int i = 0; i < ITEMS_PER_SIZE; i++) begin
				c = COORD_W'($urandom_range(0, 255));
				r = COORD_W'($urandom_range(0, 255));
				// Most positions lie inside the matrix; the rest test the wrap.
				if ($urandom_range(0, 99) < 70) begin
					c = c & COORD_W'(mask);
					r = r & COORD_W'(mask);
				end
				send_item(c, r);
			end
		end
	endtask

	// The output is held off long enough for every stage to fill and the input to stall.
	task automatic test_long_hold();
		set_size(9'd16, 9'd200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_token <= hold_token + 1;
		for (int i = 0; i < 32; i++)
			send_item(COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)));
		wait_idle();
	endtask

	task automatic test_drain_pause();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 12; i++)
			send_item(COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)));
		stop_sending();
		while (pending_thresholds.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 12; i++)
			send_item(COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_degenerate_size();
		test_oversized_size();
		test_spare_index();
		test_random_stream(23, 59);
		test_random_stream(59, 23);
		test_random_stream(0, 0);
		test_long_hold();
		test_drain_pause();
		wait_idle();
		repeat (4 * RESULT_LATENCY) @(posedge clk);
		if (fail_count == 0 && pending_thresholds.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/btg_pkg.sv
hw/rtl/btg_rank.sv
hw/rtl/bayer_threshold_generator.sv
hw/rtl/btg_checker.sv
tb/sv/tb_bayer_threshold_generator.sv
